### hdl/gdfw_pkg.sv
// shared types, constants and helpers of the depth-first walker
`default_nettype none

package gdfw_pkg;

    localparam int NODES       = 8;
    localparam int VERTEX_W    = 3;
    localparam int DEGREE_W    = 3;
    localparam int ROW_STRIDE  = 8;
    localparam int ADJ_W       = 64;
    localparam int STACK_SLOTS = 64;
    localparam int STACK_AW    = $clog2(STACK_SLOTS);
    localparam int STACK_CW    = $clog2(STACK_SLOTS + 1);
    localparam int COUNT_W     = $clog2(NODES + 1);

    // request kinds as they arrive on the slave side
    localparam logic [1:0] KIND_WALK     = 2'd0;
    localparam logic [1:0] KIND_WALK_DEG = 2'd1;
    localparam logic [1:0] KIND_DEG_ALL  = 2'd2;

    typedef enum logic [0:0] {
        OP_WALK = 1'b0,
        OP_DEG  = 1'b1
    } op_t;

    // command passed from front to back
    typedef struct packed {
        op_t                 op;
        logic                with_deg;
        logic [VERTEX_W-1:0] start;
    } cmd_t;

    // edge test on the row-major matrix
    function automatic logic has_edge(input logic [ADJ_W-1:0] adj,
                                      input logic [VERTEX_W-1:0] from_v,
                                      input logic [VERTEX_W-1:0] to_v);
        logic [5:0] bit_idx;
        bit_idx = {from_v, to_v};
        return adj[bit_idx];
    endfunction

    // in-degree over the first NODES rows, self-loops excluded
    function automatic logic [DEGREE_W-1:0] in_degree_of(input logic [ADJ_W-1:0] adj,
                                                         input logic [VERTEX_W-1:0] v);
        logic [COUNT_W:0] cnt;
        cnt = '0;
        for (int r = 0; r < NODES; r++)
        begin
            if ((VERTEX_W'(r) != v) && has_edge(adj, VERTEX_W'(r), v))
            begin
                cnt = cnt + 1'b1;
            end
        end
        return cnt[DEGREE_W-1:0];
    endfunction

endpackage

`default_nettype wire

### hdl/gdfw_front.sv
// front part: takes request beats, drops meaningless ones, queues commands
`default_nettype none

module gdfw_front
    import gdfw_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [1:0]          in_kind,
    input  wire logic [VERTEX_W-1:0] in_start,
    output logic                     cmd_valid,
    input  wire logic                cmd_ready,
    output cmd_t                     cmd
);

    localparam int QDEPTH = 2;

    cmd_t       q_mem_reg [QDEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] q_cnt_reg, q_cnt_next;

    logic accept;
    logic keep;
    logic push;
    logic pop;
    cmd_t new_cmd;

    // classify the incoming beat
    always_comb
    begin
        keep             = 1'b0;
        new_cmd.op       = OP_WALK;
        new_cmd.with_deg = 1'b0;
        new_cmd.start    = in_start;
        case (in_kind)
            KIND_WALK:
            begin
                keep = (32'(in_start) < NODES);
            end
            KIND_WALK_DEG:
            begin
                keep             = (32'(in_start) < NODES);
                new_cmd.with_deg = 1'b1;
            end
            KIND_DEG_ALL:
            begin
                keep       = 1'b1;
                new_cmd.op = OP_DEG;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign in_ready  = (q_cnt_reg != 2'(QDEPTH));
    assign accept    = in_valid && in_ready;
    assign push      = accept && keep;
    assign cmd_valid = (q_cnt_reg != 2'd0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_mem_reg[rd_ptr_reg];

    // queue pointers
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        q_cnt_next  = q_cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            q_cnt_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            q_cnt_reg  <= q_cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

`default_nettype wire

### hdl/gdfw_back.sv
// back part: walk sequencer with the pending stack and the result register
`default_nettype none

module gdfw_back
    import gdfw_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [ADJ_W-1:0]    adj,
    input  wire logic                cmd_valid,
    output logic                     cmd_ready,
    input  wire cmd_t                cmd,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [VERTEX_W-1:0]      out_vertex,
    output logic [DEGREE_W-1:0]      out_degree,
    output logic                     out_last
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SCAN = 6'b000010,
        ST_POP  = 6'b000100,
        ST_READ = 6'b001000,
        ST_EMIT = 6'b010000,
        ST_DEG  = 6'b100000
    } state_t;

    state_t                 state_reg, state_next;
    logic [VERTEX_W-1:0]    cur_reg, cur_next;
    logic [VERTEX_W-1:0]    nxt_reg, nxt_next;
    logic [VERTEX_W-1:0]    scan_reg, scan_next;
    logic [NODES-1:0]       visited_reg, visited_next;
    logic [STACK_CW-1:0]    sp_reg, sp_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic                   with_deg_reg, with_deg_next;
    logic                   last_reg, last_next;

    logic                   ov_reg, ov_next;
    logic [VERTEX_W-1:0]    ovx_reg, ovx_next;
    logic [DEGREE_W-1:0]    odg_reg, odg_next;
    logic                   olast_reg, olast_next;

    logic [VERTEX_W-1:0]    stack_mem [STACK_SLOTS];
    logic [VERTEX_W-1:0]    stack_rd_reg;
    logic                   push;
    logic                   pop;
    logic [STACK_AW-1:0]    rd_addr;
    logic                   out_free;

    assign out_free   = !ov_reg || out_ready;
    assign cmd_ready  = (state_reg == ST_IDLE);
    assign out_valid  = ov_reg;
    assign out_vertex = ovx_reg;
    assign out_degree = odg_reg;
    assign out_last   = olast_reg;
    assign rd_addr    = STACK_AW'(sp_reg - 1'b1);

    // push while scanning a row, pop until an unvisited entry turns up
    assign push = (state_reg == ST_SCAN) && has_edge(adj, cur_reg, scan_reg)
                  && !visited_reg[scan_reg] && (32'(sp_reg) < STACK_SLOTS);
    assign pop  = (state_reg == ST_POP) && (sp_reg != '0);

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        cur_next      = cur_reg;
        nxt_next      = nxt_reg;
        scan_next     = scan_reg;
        visited_next  = visited_reg;
        sp_next       = sp_reg;
        count_next    = count_reg;
        with_deg_next = with_deg_reg;
        last_next     = last_reg;
        ov_next       = ov_reg && !out_ready;
        ovx_next      = ovx_reg;
        odg_next      = odg_reg;
        olast_next    = olast_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cur_next      = cmd.start;
                    with_deg_next = cmd.with_deg;
                    visited_next  = '0;
                    sp_next       = '0;
                    count_next    = '0;
                    scan_next     = VERTEX_W'(NODES - 1);
                    if (cmd.op == OP_DEG)
                    begin
                        cur_next   = '0;
                        state_next = ST_DEG;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (push)
                begin
                    sp_next = sp_reg + 1'b1;
                end
                if (scan_reg == '0)
                begin
                    visited_next[cur_reg] = 1'b1;
                    count_next            = count_reg + 1'b1;
                    if (32'(count_reg) == NODES - 1)
                    begin
                        last_next  = 1'b1;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_POP;
                    end
                end
                else
                begin
                    scan_next = scan_reg - 1'b1;
                end
            end
            ST_POP:
            begin
                if (sp_reg == '0)
                begin
                    last_next  = 1'b1;
                    state_next = ST_EMIT;
                end
                else
                begin
                    sp_next    = sp_reg - 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (visited_reg[stack_rd_reg])
                begin
                    state_next = ST_POP;
                end
                else
                begin
                    nxt_next   = stack_rd_reg;
                    last_next  = 1'b0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    ovx_next   = cur_reg;
                    odg_next   = with_deg_reg ? in_degree_of(adj, cur_reg) : '0;
                    olast_next = last_reg;
                    if (last_reg)
                    begin
                        sp_next    = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cur_next   = nxt_reg;
                        scan_next  = VERTEX_W'(NODES - 1);
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_DEG:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    ovx_next   = cur_reg;
                    odg_next   = in_degree_of(adj, cur_reg);
                    olast_next = (32'(cur_reg) == NODES - 1);
                    if (32'(cur_reg) == NODES - 1)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cur_next = cur_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            visited_reg  <= '0;
            sp_reg       <= '0;
            count_reg    <= '0;
            last_reg     <= 1'b0;
            with_deg_reg <= 1'b0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            visited_reg  <= visited_next;
            sp_reg       <= sp_next;
            count_reg    <= count_next;
            last_reg     <= last_next;
            with_deg_reg <= with_deg_next;
            ov_reg       <= ov_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        nxt_reg   <= nxt_next;
        scan_reg  <= scan_next;
        ovx_reg   <= ovx_next;
        odg_reg   <= odg_next;
        olast_reg <= olast_next;
    end

    // pending stack, registered read
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            stack_mem[sp_reg[STACK_AW-1:0]] <= scan_reg;
        end
        if (pop)
        begin
            stack_rd_reg <= stack_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### hdl/graph_depth_first_walker_top.sv
// Depth-first walker over an 8-vertex directed graph held as a 64-bit adjacency
// matrix (bit row*8+col). A request is taken into a two-entry command queue;
// the walk sequencer picks it up while idle and then scans one adjacency column
// per cycle, and each pop of the pending stack, skipped or not, passes through
// an address step and a registered read; a pop that finds the stack empty ends
// the walk. A vertex pushes only vertices still unvisited, so eight vertices
// push at most 36 entries; an in-degree request emits one result per vertex.
// Results leave through an output register, so the sequencer only waits when
// that register is still full. The adjacency register is written over APB
// and must only change while no request is in flight.
`default_nettype none

module graph_depth_first_walker_top
    import gdfw_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    // request beat
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [7:0]       s_tdata,   // kind[1:0], start_vertex[4:2], zero[7:5]
    // result beat
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [7:0]            m_tdata,   // vertex[2:0], in_degree[5:3], zero[7:6]
    output logic                  m_tlast,
    // configuration
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [3:0]       paddr,
    input  wire logic [ADJ_W-1:0] pwdata,
    output logic [ADJ_W-1:0]      prdata,
    output logic                  pready
);

    localparam logic ADDR_ADJ = 1'b0;

    logic [ADJ_W-1:0]    adj_reg;
    logic                cmd_valid;
    logic                cmd_ready;
    cmd_t                cmd;
    logic [VERTEX_W-1:0] out_vertex;
    logic [DEGREE_W-1:0] out_degree;

    // register file
    assign pready = 1'b1;
    assign prdata = (paddr[3] == ADDR_ADJ) ? adj_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            adj_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && (paddr[3] == ADDR_ADJ))
        begin
            adj_reg <= pwdata;
        end
    end

    gdfw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_kind   (s_tdata[1:0]),
        .in_start  (s_tdata[4:2]),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    gdfw_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .adj        (adj_reg),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_vertex (out_vertex),
        .out_degree (out_degree),
        .out_last   (m_tlast)
    );

    // result packing
    assign m_tdata = {2'b00, out_degree, out_vertex};

endmodule

`default_nettype wire

### hdl/gdfw_checker.sv
// port-level checks of the walker, bound to the top level
`default_nettype none

module gdfw_checker
    import gdfw_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             m_tvalid,
    input  wire logic             m_tready,
    input  wire logic [7:0]       m_tdata,
    input  wire logic             m_tlast,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [3:0]       paddr,
    input  wire logic [ADJ_W-1:0] pwdata,
    input  wire logic [ADJ_W-1:0] prdata,
    input  wire logic             pready
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // padding bits of a result stay zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[7:6] == 2'b00))
        else $error("result padding not zero");

    // configuration port never waits
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

    // adjacency write reads back
    a_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && (paddr == 4'd0) |=> (prdata == $past(pwdata))
            || (paddr != 4'd0))
        else $error("adjacency readback mismatch");

endmodule

bind graph_depth_first_walker_top gdfw_checker u_gdfw_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
);

`default_nettype wire

### tb/graph_depth_first_walker_top_test.sv
// self-checking testbench for the depth-first walker: table, random phases, stream checks
`default_nettype none

module graph_depth_first_walker_top_test;
    import gdfw_pkg::*;

    // request kind with no meaning, not in the package
    localparam logic [1:0] KIND_UNUSED    = 2'd3;
    localparam logic [3:0] REG_ADJACENCY  = 4'd0;
    localparam int         SETTLE_CYCLES  = 300;
    localparam int         PHASES         = 6;
    localparam int         ITEMS_PER_PHASE = 21;
    localparam int         DIRECTED_ROWS  = 18;

    typedef struct packed {
        logic [VERTEX_W-1:0] vertex;
        logic [DEGREE_W-1:0] in_degree;
        logic                last;
    } visit_t;

    // one directed row: optional matrix load, then one request
    typedef struct packed {
        bit                  load_adj;
        logic [ADJ_W-1:0]    adj;
        logic [1:0]          kind;
        logic [VERTEX_W-1:0] start;
        bit                  typed;
        logic [3:0]          n_results;
        logic [DEGREE_W-1:0] degree;
    } directed_row_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata = '0;    // kind[1:0], start_vertex[4:2], zero[7:5]
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [7:0]       m_tdata;         // vertex[2:0], in_degree[5:3], zero[7:6]
    logic             m_tlast;
    logic             psel = 1'b0;
    logic             penable = 1'b0;
    logic             pwrite = 1'b0;
    logic [3:0]       paddr = '0;
    logic [ADJ_W-1:0] pwdata = '0;
    logic [ADJ_W-1:0] prdata;
    logic             pready;

    logic [ADJ_W-1:0] adjacency_shadow = '0;
    visit_t           pending_visits[$];
    int               fail_count = 0;
    int               burst_left = 0;
    bit               steady_sender = 1'b0;
    logic [15:0]      rx_cycle = '0;
    logic [1:0]       rx_mode = 2'd0;

    directed_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
        // after reset the matrix is empty
        '{1'b0, 64'h0, KIND_WALK,     3'd0, 1'b1, 4'd1, 3'd0},
        '{1'b0, 64'h0, KIND_WALK_DEG, 3'd7, 1'b1, 4'd1, 3'd0},
        '{1'b0, 64'h0, KIND_DEG_ALL,  3'd3, 1'b1, 4'd8, 3'd0},
        '{1'b0, 64'h0, KIND_UNUSED,   3'd5, 1'b1, 4'd0, 3'd0},
        // complete graph with self-loops
        '{1'b1, 64'hFFFF_FFFF_FFFF_FFFF, KIND_DEG_ALL,  3'd0, 1'b1, 4'd8, 3'd7},
        '{1'b0, 64'h0, KIND_WALK,     3'd0, 1'b0, 4'd0, 3'd0},
        '{1'b0, 64'h0, KIND_WALK_DEG, 3'd7, 1'b0, 4'd0, 3'd0},
        '{1'b0, 64'h0, KIND_UNUSED,   3'd7, 1'b1, 4'd0, 3'd0},
        // self-loops only, none counted
        '{1'b1, 64'h8040_2010_0804_0201, KIND_DEG_ALL,  3'd6, 1'b1, 4'd8, 3'd0},
        '{1'b0, 64'h0, KIND_WALK_DEG, 3'd4, 1'b1, 4'd1, 3'd0},
        // diamond: vertex 2 is pushed twice and popped once already visited
        '{1'b1, 64'h0000_0000_0000_0406, KIND_WALK,     3'd0, 1'b0, 4'd0, 3'd0},
        '{1'b0, 64'h0, KIND_WALK_DEG, 3'd1, 1'b0, 4'd0, 3'd0},
        // ring through all eight vertices, walk ends on the vertex limit
        '{1'b1, 64'h0180_4020_1008_0402, KIND_DEG_ALL,  3'd2, 1'b1, 4'd8, 3'd1},
        '{1'b0, 64'h0, KIND_WALK,     3'd3, 1'b0, 4'd0, 3'd0},
        '{1'b0, 64'h0, KIND_WALK_DEG, 3'd5, 1'b0, 4'd0, 3'd0},
        // alternating bit patterns
        '{1'b1, 64'hAAAA_AAAA_AAAA_AAAA, KIND_DEG_ALL,  3'd1, 1'b0, 4'd0, 3'd0},
        '{1'b1, 64'h5555_5555_5555_5555, KIND_WALK_DEG, 3'd6, 1'b0, 4'd0, 3'd0},
        '{1'b0, 64'h0, KIND_DEG_ALL,  3'd4, 1'b0, 4'd0, 3'd0}
    };

    graph_depth_first_walker_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    initial
    begin
        forever
        begin
            #1 clk = ~clk;
        end
    end

    // overall time limit
    initial
    begin
        #1000000;
        $display("[graph_depth_first_walker_top] ERROR");
        $finish;
    end

    // number of other vertices with an edge into v
    function automatic logic [DEGREE_W-1:0] count_in_edges(input logic [ADJ_W-1:0] adj,
                                                          input int v);
        int n;
        n = 0;
        for (int r = 0; r < NODES; r++)
        begin
            if (r != v && adj[r*ROW_STRIDE + v])
            begin
                n++;
            end
        end
        return n[DEGREE_W-1:0];
    endfunction

    // visit order of one request, queued as expected result beats
    task automatic predict_visits(input logic [1:0] kind, input logic [VERTEX_W-1:0] start);
        logic [NODES-1:0] seen;
        int               stack[$];
        int               order[$];
        int               cur;
        bit               found;
        visit_t           beat;
        seen = '0;
        if (kind == KIND_DEG_ALL)
        begin
            for (int v = 0; v < NODES; v++)
            begin
                order.push_back(v);
            end
        end
        else if ((kind == KIND_WALK || kind == KIND_WALK_DEG) && int'(start) < NODES)
        begin
            cur = start;
            while (order.size() < NODES)
            begin
                // unvisited neighbours, highest index pushed first
                for (int r = NODES - 1; r >= 0; r--)
                begin
                    if (adjacency_shadow[cur*ROW_STRIDE + r] && !seen[r])
                    begin
                        stack.push_back(r);
                    end
                end
                order.push_back(cur);
                seen[cur] = 1'b1;
                // pop until an unvisited vertex turns up
                found = 1'b0;
                while (stack.size() > 0 && !found)
                begin
                    cur = stack.pop_back();
                    found = !seen[cur];
                end
                if (!found)
                begin
                    break;
                end
            end
        end
        for (int i = 0; i < order.size(); i++)
        begin
            beat.vertex    = order[i][VERTEX_W-1:0];
            beat.in_degree = (kind == KIND_WALK) ? '0 : count_in_edges(adjacency_shadow, order[i]);
            beat.last      = (i == order.size() - 1);
            pending_visits.push_back(beat);
        end
    endtask

    // present one request beat, bursts with random gaps between them
    task automatic send_request(input logic [1:0] kind, input logic [VERTEX_W-1:0] start);
        int gap;
        if (burst_left == 0)
        begin
            gap = steady_sender ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, start, kind};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
    endtask

    // stop sending, let every result drain and the walker go quiet
    task automatic drain_walker();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_visits.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // apb write of the matrix, then read it back
    task automatic load_adjacency(input logic [ADJ_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_ADJACENCY;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        adjacency_shadow = value;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        if (prdata !== value)
        begin
            $error("adjacency_bits: expected %h, got %h", value, prdata);
            fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // random matrix of a density picked by phase
    function automatic logic [ADJ_W-1:0] random_adjacency(input int phase);
        logic [ADJ_W-1:0] a;
        logic [ADJ_W-1:0] b;
        logic [ADJ_W-1:0] c;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        c = {$urandom, $urandom};
        case (phase % 4)
            0:       return a & b & c;
            1:       return a & b;
            2:       return a;
            default: return a | b;
        endcase
    endfunction

    // receiver stall pattern, mode picked anew whenever the low byte of rx_cycle is zero
    always @(posedge clk)
    begin
        rx_cycle <= rx_cycle + 1'b1;
        if (rx_cycle[7:0] == 8'd0)
        begin
            rx_mode <= 2'($urandom_range(0, 3));
        end
        case (rx_mode)
            2'd0:    m_tready <= 1'b1;
            2'd1:    m_tready <= 1'($urandom_range(0, 1));
            2'd2:    m_tready <= (rx_cycle[1:0] == 2'd0);
            default: m_tready <= rx_cycle[4];
        endcase
    end

    // result beat checker
    always @(posedge clk)
    begin
        visit_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_visits.size() == 0)
            begin
                $error("unexpected result beat: vertex %0d", m_tdata[2:0]);
                fail_count++;
            end
            else
            begin
                want = pending_visits.pop_front();
                if (m_tdata[2:0] !== want.vertex)
                begin
                    $error("vertex: expected %0d, got %0d", want.vertex, m_tdata[2:0]);
                    fail_count++;
                end
                if (m_tdata[5:3] !== want.in_degree)
                begin
                    $error("in_degree: expected %0d, got %0d", want.in_degree, m_tdata[5:3]);
                    fail_count++;
                end
                if (m_tlast !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    // stimulus
    initial
    begin
        directed_row_t row;
        visit_t        beat;
        logic [1:0]    kind;
        int            counted;
        int            pick;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            row = directed_rows[i];
            steady_sender = (i % 5) < 2;
            if (row.load_adj)
            begin
                drain_walker();
                load_adjacency(row.adj);
            end
            send_request(row.kind, row.start);
            if (row.typed)
            begin
                for (int k = 0; k < row.n_results; k++)
                begin
                    beat.vertex    = (row.n_results == 1) ? row.start : k[VERTEX_W-1:0];
                    beat.in_degree = row.degree;
                    beat.last      = (k == row.n_results - 1);
                    pending_visits.push_back(beat);
                end
            end
            else
            begin
                predict_visits(row.kind, row.start);
            end
        end

        // random phases, each with a fresh matrix
        for (int p = 0; p < PHASES; p++)
        begin
            drain_walker();
            load_adjacency(random_adjacency(p));
            steady_sender = p[0];
            counted = 0;
            while (counted < ITEMS_PER_PHASE)
            begin
                pick = $urandom_range(0, 15);
                if (pick < 6)
                    kind = KIND_WALK;
                else if (pick < 11)
                    kind = KIND_WALK_DEG;
                else if (pick < 15)
                    kind = KIND_DEG_ALL;
                else
                    kind = KIND_UNUSED;
                send_request(kind, VERTEX_W'($urandom_range(0, 7)));
                predict_visits(kind, s_tdata[4:2]);
                if (kind != KIND_UNUSED)
                begin
                    counted++;
                end
            end
        end

        // wait for the last results and a quiet tail
        drain_walker();
        if (fail_count == 0)
        begin
            $display("[graph_depth_first_walker_top] OK");
        end
        else
        begin
            $display("[graph_depth_first_walker_top] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
